[hdl/lrpwm_pkg.sv]
// ----------------------------------------------------------------------------
// LED ring PWM package
// Shared types, command codes, register indexes and PWM constants.
// ----------------------------------------------------------------------------
package lrpwm_pkg;

    // Ring geometry
    localparam int NUM_LEDS  = 8;
    localparam int LED_IDX_W = $clog2(NUM_LEDS);
    localparam int DUTY_W    = 7;

    typedef logic [DUTY_W-1:0]    duty_t;
    typedef logic [NUM_LEDS-1:0]  led_vec_t;
    typedef logic [LED_IDX_W-1:0] led_idx_t;

    // PWM timing
    localparam duty_t PWM_PERIOD = duty_t'(100);
    localparam duty_t FULL_DUTY  = duty_t'(100);

    // Register reset values
    localparam duty_t DIM_RESET    = duty_t'(10);
    localparam duty_t BRIGHT_RESET = duty_t'(100);

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_MASK  = 2'd1;
    localparam logic [1:0] CMD_SPOT  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic REG_DIM    = 1'b0;
    localparam logic REG_BRIGHT = 1'b1;

endpackage

[hdl/led_ring_pwm_controller_top.sv]
// ----------------------------------------------------------------------------
// LED ring PWM controller
// Eight-channel PWM for a ring of LEDs, driven by tick / mask / spotlight
// command words.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (item_valid/item_ready, cmd, led_mask): tick, set-mask or
//   spotlight words. Mask and spotlight update the duty settings and return
//   nothing; a tick returns one result word.
//   Result channel (result_valid/result_ready, drive_mask, period_start):
//   LEDs on during the tick, and a flag when the tick reloaded the counts.
//   Config port (cfg_we, cfg_index, cfg_data): dim and bright levels, to be
//   written only while no command is in flight; the block does not check it.
//   A tick word passes through the input register, then the result register.
//   Throughput: one word per cycle while no tick waits on a stalled result;
//   the eight duty counters and the phase counter all update in parallel,
//   behind an input register, with a result register on the output side.
//   Reset clears settings, counters and valid flags; levels go to 10 / 100.
//   When the receiver stalls, the result register holds and the input
//   register fills; item_ready drops only if a tick waits behind a full
//   result register.
// ----------------------------------------------------------------------------
module led_ring_pwm_controller_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  led_mask,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  drive_mask,
    output logic        period_start,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    // Configuration registers
    lrpwm_pkg::duty_t dim_reg;
    lrpwm_pkg::duty_t bright_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg    <= lrpwm_pkg::DIM_RESET;
            bright_reg <= lrpwm_pkg::BRIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lrpwm_pkg::REG_DIM:    dim_reg    <= cfg_data;
                lrpwm_pkg::REG_BRIGHT: bright_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    logic                  s0_valid_reg;
    logic [1:0]            s0_cmd_reg;
    lrpwm_pkg::led_vec_t   s0_mask_reg;
    logic                  s0_is_tick;
    logic                  s0_advance;
    logic                  out_load;

    assign s0_is_tick = (s0_cmd_reg == lrpwm_pkg::CMD_TICK);
    assign out_load   = s0_valid_reg && s0_is_tick && (!result_valid || result_ready);
    assign s0_advance = s0_valid_reg && (!s0_is_tick || !result_valid || result_ready);
    assign item_ready = !s0_valid_reg || s0_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s0_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s0_cmd_reg  <= cmd;
            s0_mask_reg <= led_mask;
        end
    end

    // Highest set bit of the mask; an empty mask selects LED 0
    lrpwm_pkg::led_idx_t spot_top;
    lrpwm_pkg::led_idx_t spot_lo;
    lrpwm_pkg::led_idx_t spot_hi;

    always_comb
    begin
        spot_top = '0;
        for (int i = 0; i < lrpwm_pkg::NUM_LEDS; i++)
        begin
            if (s0_mask_reg[i])
            begin
                spot_top = lrpwm_pkg::led_idx_t'(i);
            end
        end
    end

    // Ring neighbors wrap through the index width
    assign spot_lo = spot_top - lrpwm_pkg::led_idx_t'(1);
    assign spot_hi = spot_top + lrpwm_pkg::led_idx_t'(1);

    // Duty settings, remaining counts and phase counter
    lrpwm_pkg::duty_t    duty_setting_reg   [lrpwm_pkg::NUM_LEDS];
    lrpwm_pkg::duty_t    duty_setting_next  [lrpwm_pkg::NUM_LEDS];
    lrpwm_pkg::duty_t    duty_remaining_reg [lrpwm_pkg::NUM_LEDS];
    lrpwm_pkg::duty_t    duty_remaining_next[lrpwm_pkg::NUM_LEDS];
    lrpwm_pkg::duty_t    duty_loaded        [lrpwm_pkg::NUM_LEDS];
    lrpwm_pkg::duty_t    phase_reg;
    lrpwm_pkg::duty_t    phase_next;
    lrpwm_pkg::led_vec_t drive_calc;
    logic                reload;

    assign reload = (phase_reg == '0);

    // Tick: reload at phase zero, drive nonzero counts, count down
    always_comb
    begin
        for (int i = 0; i < lrpwm_pkg::NUM_LEDS; i++)
        begin
            duty_loaded[i]         = reload ? duty_setting_reg[i] : duty_remaining_reg[i];
            drive_calc[i]          = (duty_loaded[i] != '0);
            duty_remaining_next[i] = duty_loaded[i]
                                   - lrpwm_pkg::duty_t'(drive_calc[i]);
        end
        phase_next = (reload ? lrpwm_pkg::PWM_PERIOD : phase_reg)
                   - lrpwm_pkg::duty_t'(1);
    end

    // Mask and spotlight update the duty settings
    always_comb
    begin
        for (int i = 0; i < lrpwm_pkg::NUM_LEDS; i++)
        begin
            duty_setting_next[i] = duty_setting_reg[i];
        end
        unique case (s0_cmd_reg)
            lrpwm_pkg::CMD_MASK:
            begin
                for (int i = 0; i < lrpwm_pkg::NUM_LEDS; i++)
                begin
                    duty_setting_next[i] = s0_mask_reg[i] ? lrpwm_pkg::FULL_DUTY : '0;
                end
            end
            lrpwm_pkg::CMD_SPOT:
            begin
                for (int i = 0; i < lrpwm_pkg::NUM_LEDS; i++)
                begin
                    if (lrpwm_pkg::led_idx_t'(i) == spot_top)
                    begin
                        duty_setting_next[i] = bright_reg;
                    end
                    else if (lrpwm_pkg::led_idx_t'(i) == spot_lo ||
                             lrpwm_pkg::led_idx_t'(i) == spot_hi)
                    begin
                        duty_setting_next[i] = dim_reg;
                    end
                    else
                    begin
                        duty_setting_next[i] = '0;
                    end
                end
            end
            lrpwm_pkg::CMD_TICK, lrpwm_pkg::CMD_NONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lrpwm_pkg::NUM_LEDS; i++)
            begin
                duty_setting_reg[i]   <= '0;
                duty_remaining_reg[i] <= '0;
            end
            phase_reg <= '0;
        end
        else if (s0_advance)
        begin
            for (int i = 0; i < lrpwm_pkg::NUM_LEDS; i++)
            begin
                duty_setting_reg[i] <= duty_setting_next[i];
            end
            if (s0_is_tick)
            begin
                for (int i = 0; i < lrpwm_pkg::NUM_LEDS; i++)
                begin
                    duty_remaining_reg[i] <= duty_remaining_next[i];
                end
                phase_reg <= phase_next;
            end
        end
    end

    // Result register
    logic                result_valid_reg;
    lrpwm_pkg::led_vec_t drive_mask_reg;
    logic                period_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            drive_mask_reg   <= drive_calc;
            period_start_reg <= reload;
        end
    end

    assign result_valid = result_valid_reg;
    assign drive_mask   = drive_mask_reg;
    assign period_start = period_start_reg;

`ifndef SYNTHESIS
    // Phase counter stays inside the period
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < lrpwm_pkg::PWM_PERIOD)
        else $error("phase counter out of range");

    // A reloading tick restarts the phase at the top of the period
    a_phase_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_advance && s0_is_tick && reload)
        |=> (phase_reg == lrpwm_pkg::PWM_PERIOD - lrpwm_pkg::duty_t'(1)))
        else $error("phase not restarted after reload");

    // Period start flag matches the phase that produced the result
    a_start_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (period_start_reg == ($past(phase_reg) == '0)))
        else $error("period start flag mismatch");

    // A held input word keeps its command while it waits
    a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_valid_reg && !s0_advance) |=> (s0_valid_reg && $stable(s0_cmd_reg)))
        else $error("input register lost a stalled word");
`endif

endmodule

[tb/led_ring_pwm_controller_top_tb.sv]
// ----------------------------------------------------------------------------
// LED ring PWM controller testbench
// Drives tick, set-mask, spotlight and unused command words under random
// sender gaps and receiver stalls. Dim and bright levels are stepped through
// several settings, the extremes among them. A tracker keeps its own copy of
// the duty settings, remaining counts and phase counter, and it checks every
// result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_ring_pwm_controller_top_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_WORDS   = 170;

    // One expected tick result
    typedef struct packed {
        lrpwm_pkg::led_vec_t drive;
        logic                start;
    } tick_t;

    // Tracks duty state and holds the tick results still to come
    class ring_pwm_tracker;
        lrpwm_pkg::duty_t duty_set[lrpwm_pkg::NUM_LEDS];
        lrpwm_pkg::duty_t duty_left[lrpwm_pkg::NUM_LEDS];
        lrpwm_pkg::duty_t phase;
        lrpwm_pkg::duty_t dim;
        lrpwm_pkg::duty_t bright;
        tick_t pending_ticks[$];
        int    mismatches;
        int    ticks_seen;
        int    reloads_seen;
        int    duty_updates;
        int    ignored_words;

        function new();
            foreach (duty_set[i])
            begin
                duty_set[i]  = '0;
                duty_left[i] = '0;
            end
            phase         = '0;
            dim           = lrpwm_pkg::DIM_RESET;
            bright        = lrpwm_pkg::BRIGHT_RESET;
            mismatches    = 0;
            ticks_seen    = 0;
            reloads_seen  = 0;
            duty_updates  = 0;
            ignored_words = 0;
        endfunction

        function void set_level(logic idx, lrpwm_pkg::duty_t value);
            if (idx == lrpwm_pkg::REG_DIM)
                dim = value;
            else
                bright = value;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        // Update state for one accepted command word
        function void note_word(logic [1:0] op, lrpwm_pkg::led_vec_t mask);
            tick_t expt;
            int    top;
            begin
                case (op)
                    lrpwm_pkg::CMD_TICK:
                    begin
                        expt.drive = '0;
                        expt.start = 1'b0;
                        if (phase == '0)
                        begin
                            phase = lrpwm_pkg::PWM_PERIOD;
                            foreach (duty_left[i])
                                duty_left[i] = duty_set[i];
                            expt.start = 1'b1;
                        end
                        foreach (duty_left[i])
                        begin
                            if (duty_left[i] != '0)
                            begin
                                expt.drive[i] = 1'b1;
                                duty_left[i]  = duty_left[i] - 1'b1;
                            end
                        end
                        phase = phase - 1'b1;
                        pending_ticks.push_back(expt);
                    end
                    lrpwm_pkg::CMD_MASK:
                    begin
                        foreach (duty_set[i])
                            duty_set[i] = mask[i] ? lrpwm_pkg::FULL_DUTY
                                                  : lrpwm_pkg::duty_t'(0);
                        duty_updates++;
                    end
                    lrpwm_pkg::CMD_SPOT:
                    begin
                        // highest set bit; an empty mask lands on LED 0
                        top = 0;
                        for (int i = 0; i < lrpwm_pkg::NUM_LEDS; i++)
                            if (mask[i])
                                top = i;
                        foreach (duty_set[i])
                            duty_set[i] = '0;
                        duty_set[(top + lrpwm_pkg::NUM_LEDS - 1) % lrpwm_pkg::NUM_LEDS] = dim;
                        duty_set[(top + 1) % lrpwm_pkg::NUM_LEDS]                       = dim;
                        duty_set[top]                                                   = bright;
                        duty_updates++;
                    end
                    default:
                        ignored_words++;
                endcase
            end
        endfunction

        // Compare one result word against the oldest expected tick
        function void check_tick(lrpwm_pkg::led_vec_t drive, logic start);
            tick_t expt;
            begin
                if (pending_ticks.size() == 0)
                begin
                    report($sformatf("result with no tick pending: drive %02h start %0b",
                                     drive, start));
                    return;
                end
                expt = pending_ticks.pop_front();
                ticks_seen++;
                if (start)
                    reloads_seen++;
                if (drive !== expt.drive)
                    report($sformatf("tick %0d drive_mask exp %02h got %02h",
                                     ticks_seen, expt.drive, drive));
                if (start !== expt.start)
                    report($sformatf("tick %0d period_start exp %0b got %0b",
                                     ticks_seen, expt.start, start));
            end
        endfunction

        function int pending();
            return pending_ticks.size();
        endfunction
    endclass

    // DUT signals
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    logic [1:0]          cmd          = lrpwm_pkg::CMD_TICK;
    lrpwm_pkg::led_vec_t led_mask     = '0;
    logic                result_valid;
    logic                result_ready = 1'b1;
    lrpwm_pkg::led_vec_t drive_mask;
    logic                period_start;
    logic                cfg_we       = 1'b0;
    logic                cfg_index    = lrpwm_pkg::REG_DIM;
    lrpwm_pkg::duty_t    cfg_data     = '0;

    ring_pwm_tracker track = new();

    int cycles       = 0;
    int gap_pct      = 25;
    int stall_pct    = 20;
    int stall_left   = 0;
    int settings_run = 1;
    bit quiet        = 1'b0;

    led_ring_pwm_controller_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .led_mask     (led_mask),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .drive_mask   (drive_mask),
        .period_start (period_start),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d ticks pending", cycles, track.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (!quiet && rst_n && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            track.check_tick(drive_mask, period_start);
    end

    // Present one command word and hold it until accepted
    task automatic send_word(input logic [1:0] op, input lrpwm_pkg::led_vec_t mask);
        item_valid <= 1'b1;
        cmd        <= op;
        led_mask   <= mask;
        do
            @(posedge clk);
        while (!item_ready);
        track.note_word(op, mask);
    endtask

    task automatic idle_sender(input int n);
        item_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off until every tick result is back and the pipe is empty
    task automatic drain();
        item_valid <= 1'b0;
        while (track.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the dim level, then the bright level; block must be idle
    task automatic write_levels(input lrpwm_pkg::duty_t dim_val,
                                input lrpwm_pkg::duty_t bright_val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= lrpwm_pkg::REG_DIM;
        cfg_data  <= dim_val;
        @(posedge clk);
        track.set_level(lrpwm_pkg::REG_DIM, dim_val);
        cfg_index <= lrpwm_pkg::REG_BRIGHT;
        cfg_data  <= bright_val;
        @(posedge clk);
        track.set_level(lrpwm_pkg::REG_BRIGHT, bright_val);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Random word: mostly ticks so reloads come often
    task automatic send_random();
        int                  pick;
        int                  top;
        lrpwm_pkg::led_vec_t mask;
        begin
            pick = $urandom_range(0, 99);
            mask = lrpwm_pkg::led_vec_t'($urandom);
            if (pick < 70)
                send_word(lrpwm_pkg::CMD_TICK, mask);
            else if (pick < 82)
                send_word(lrpwm_pkg::CMD_MASK, mask);
            else if (pick < 94)
            begin
                // half the time pick the top LED directly
                if ($urandom_range(0, 1) == 1)
                begin
                    top  = $urandom_range(0, lrpwm_pkg::NUM_LEDS - 1);
                    mask = lrpwm_pkg::led_vec_t'(1 << top)
                         | (mask & lrpwm_pkg::led_vec_t'((1 << top) - 1));
                end
                send_word(lrpwm_pkg::CMD_SPOT, mask);
            end
            else
                send_word(lrpwm_pkg::CMD_NONE, mask);
            if (!quiet && $urandom_range(0, 99) < gap_pct)
                idle_sender($urandom_range(1, 4));
        end
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
        begin
            // vary pressure in stretches, some without any idling
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: begin gap_pct = 0;  stall_pct = 0;  end
                    1: begin gap_pct = 25; stall_pct = 20; end
                    default: begin gap_pct = 50; stall_pct = 40; end
                endcase
            end
            send_random();
        end
    endtask

    // Stimulus
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, mask extremes, spotlight wrap, unused command
        send_word(lrpwm_pkg::CMD_TICK, 8'h00);
        send_word(lrpwm_pkg::CMD_TICK, 8'hFF);
        send_word(lrpwm_pkg::CMD_MASK, 8'hFF);
        send_word(lrpwm_pkg::CMD_TICK, 8'h00);
        send_word(lrpwm_pkg::CMD_NONE, 8'hFF);
        send_word(lrpwm_pkg::CMD_NONE, 8'h00);
        send_word(lrpwm_pkg::CMD_SPOT, 8'h00);
        send_word(lrpwm_pkg::CMD_TICK, 8'h00);
        send_word(lrpwm_pkg::CMD_SPOT, 8'h80);
        send_word(lrpwm_pkg::CMD_SPOT, 8'h01);
        send_word(lrpwm_pkg::CMD_SPOT, 8'hFF);
        send_word(lrpwm_pkg::CMD_SPOT, 8'h5A);
        send_word(lrpwm_pkg::CMD_MASK, 8'h00);
        send_word(lrpwm_pkg::CMD_MASK, 8'hA5);
        send_word(lrpwm_pkg::CMD_TICK, 8'h5A);
        send_word(lrpwm_pkg::CMD_MASK, 8'h5A);
        send_word(lrpwm_pkg::CMD_SPOT, 8'h10);
        send_word(lrpwm_pkg::CMD_TICK, 8'hA5);
        send_word(lrpwm_pkg::CMD_TICK, 8'h00);

        // random phases over several level settings
        random_phase(PHASE_WORDS);
        write_levels(7'd0, 7'd0);
        random_phase(PHASE_WORDS);
        write_levels(7'd127, 7'd127);
        random_phase(PHASE_WORDS / 2);
        drain();
        random_phase(PHASE_WORDS / 2);
        write_levels(7'd100, 7'd0);
        random_phase(PHASE_WORDS);
        write_levels(7'd0, 7'd100);
        random_phase(PHASE_WORDS);
        write_levels(lrpwm_pkg::duty_t'($urandom_range(0, 127)),
                     lrpwm_pkg::duty_t'($urandom_range(0, 127)));
        random_phase(PHASE_WORDS);

        // last stretch with no idling on either side
        write_levels(lrpwm_pkg::DIM_RESET, lrpwm_pkg::BRIGHT_RESET);
        quiet = 1'b1;
        random_phase(PHASE_WORDS);

        drain();
        repeat (8) @(posedge clk);

        $display("Covered %0d tick words with %0d period reloads, %0d duty updates, %0d ignored",
                 track.ticks_seen, track.reloads_seen, track.duty_updates, track.ignored_words);
        $display("words, over %0d level settings; %0d mismatches",
                 settings_run, track.mismatches);
        if (track.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
